// ----- hw/rtl/rdbs_pkg.sv -----
// shared types and constants for the byte store unit
package rdbs_pkg;

	localparam int unsigned MEM_BYTES_DEF = 4096;

	typedef enum logic [2:0] {
		CMD_BYTE_RD = 3'd0,
		CMD_BYTE_WR = 3'd1,
		CMD_BULK_RD = 3'd2,
		CMD_BULK_WR = 3'd3,
		CMD_SET_POS = 3'd4,
		CMD_WINDOW  = 3'd5,
		CMD_CLEAR   = 3'd6,
		CMD_STATS   = 3'd7
	} cmd_e_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_DROP   = 2'd2;

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_CALC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic commit;
		logic sweep;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic is_clear;
	} dp_stat_t;

endpackage

// ----- hw/rtl/rdbs_ctrl.sv -----
// controller state machine for the byte store unit
module rdbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rdbs_pkg::dp_stat_t stat,
	output rdbs_pkg::dp_cmd_t  ctl
);
	import rdbs_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   commit;

	assign commit = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_SWEEP: begin
				if (stat.sweep_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_n = S_CALC;
				end
			end
			S_CALC: begin
				state_n = S_DONE;
			end
			S_DONE: begin
				if (commit) begin
					state_n = stat.is_clear ? S_SWEEP : S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.load   = (state_q == S_IDLE) && in_valid;
		ctl.calc   = (state_q == S_CALC);
		ctl.commit = commit;
		ctl.sweep  = (state_q == S_SWEEP);
		in_stall   = (state_q != S_IDLE);
		out_valid  = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rise_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(commit))
		else $error("result shown without a commit");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (in_stall && !ctl.commit))
		else $error("activity during fill sweep");

	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && stat.is_clear) |=> (state_q == S_SWEEP))
		else $error("clear did not start a fill sweep");

endmodule

// ----- hw/rtl/rdbs_dp.sv -----
// datapath of the byte store unit: memory, pointer, transfer state, counters
module rdbs_dp #(
	parameter int unsigned MEM_BYTES = rdbs_pkg::MEM_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rdbs_pkg::dp_cmd_t  ctl,
	output rdbs_pkg::dp_stat_t stat,
	input  logic [2:0]         cmd,
	input  logic [7:0]         data,
	input  logic [15:0]        length,
	input  logic               first,
	input  logic               last,
	input  logic [15:0]        new_position,
	input  logic [15:0]        block_number,
	input  logic [15:0]        block_size,
	input  logic [15:0]        block_count,
	output logic [1:0]         status,
	output logic [7:0]         read_data,
	output logic [12:0]        actual_length,
	output logic [12:0]        position_now,
	output logic [31:0]        total_read,
	output logic [31:0]        total_written,
	output logic [31:0]        read_count,
	output logic [31:0]        write_count
);
	import rdbs_pkg::*;

	localparam int unsigned AW = $clog2(MEM_BYTES);
	localparam int unsigned PW = $clog2(MEM_BYTES + 1);
	localparam int unsigned CW = 34;
	localparam logic [CW-1:0] MEM_X     = CW'(MEM_BYTES);
	localparam logic [PW-1:0] MEM_P     = PW'(MEM_BYTES);
	localparam logic [PW:0]   MEM_P1    = (PW+1)'(MEM_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

	logic [7:0] mem [MEM_BYTES];

	// latched item
	cmd_e_t      cmd_q;
	logic [7:0]  data_q;
	logic [15:0] length_q;
	logic        first_q;
	logic        last_q;
	logic [15:0] newpos_q;
	logic [15:0] bnum_q;
	logic [15:0] bsize_q;
	logic [15:0] bcount_q;

	// architectural state
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] offset_q;
	logic [PW-1:0] limit_q;
	logic          rej_q;
	logic [31:0]   bytes_out_q;
	logic [31:0]   bytes_in_q;
	logic [31:0]   reads_q;
	logic [31:0]   writes_q;
	logic [7:0]    fill_q;
	logic [AW-1:0] sweep_addr_q;

	// calc results
	logic          acc_ok_q;
	logic [AW-1:0] addr_q;
	logic [PW-1:0] off_eff_q;
	logic [PW-1:0] lim_eff_q;
	logic          rej_eff_q;
	logic [31:0]   prod_off_q;
	logic [31:0]   prod_span_q;
	logic [7:0]    rd_q;

	// calc stage logic
	logic [PW-1:0] room;
	logic          open_rej;
	logic [PW-1:0] open_lim;
	logic [PW-1:0] off_eff;
	logic [PW-1:0] lim_eff;
	logic          rej_eff;
	logic [PW:0]   bulk_addr;
	logic          bulk_hit;
	logic          ptr_in;
	logic          acc_ok;
	logic [AW-1:0] rd_addr;

	always_comb begin
		room     = MEM_P - ptr_q;
		open_rej = (length_q == 16'd0) || (room == '0);
		if (open_rej) begin
			open_lim = '0;
		end else if (CW'(length_q) > CW'(room)) begin
			open_lim = room;
		end else begin
			open_lim = PW'(length_q);
		end
		off_eff   = first_q ? '0 : offset_q;
		lim_eff   = first_q ? open_lim : limit_q;
		rej_eff   = first_q ? open_rej : rej_q;
		bulk_addr = {1'b0, ptr_q} + {1'b0, off_eff};
		bulk_hit  = (off_eff < lim_eff) && (bulk_addr < MEM_P1);
		ptr_in    = (ptr_q < MEM_P);
		case (cmd_q)
			CMD_BYTE_RD, CMD_BYTE_WR: begin
				acc_ok  = ptr_in;
				rd_addr = ptr_q[AW-1:0];
			end
			CMD_BULK_RD, CMD_BULK_WR: begin
				acc_ok  = !rej_eff && bulk_hit;
				rd_addr = bulk_addr[AW-1:0];
			end
			default: begin
				acc_ok  = 1'b0;
				rd_addr = ptr_q[AW-1:0];
			end
		endcase
	end

	// commit stage logic
	logic [CW-1:0] win_sum;
	logic          win_ok;
	logic [PW:0]   bulk_np;
	logic [PW-1:0] bulk_np_sat;
	logic [PW-1:0] ptr_n;
	logic [PW-1:0] offset_n;
	logic [PW-1:0] limit_n;
	logic          rej_n;
	logic [31:0]   bytes_out_n;
	logic [31:0]   bytes_in_n;
	logic [31:0]   reads_n;
	logic [31:0]   writes_n;
	logic [1:0]    status_n;
	logic [7:0]    rdata_n;
	logic [PW-1:0] alen_n;
	logic          wr_en;

	always_comb begin
		win_sum     = CW'(prod_off_q) + CW'(prod_span_q);
		win_ok      = (win_sum <= MEM_X);
		bulk_np     = {1'b0, ptr_q} + {1'b0, lim_eff_q};
		bulk_np_sat = (bulk_np > MEM_P1) ? MEM_P : bulk_np[PW-1:0];
		ptr_n       = ptr_q;
		offset_n    = offset_q;
		limit_n     = limit_q;
		rej_n       = rej_q;
		bytes_out_n = bytes_out_q;
		bytes_in_n  = bytes_in_q;
		reads_n     = reads_q;
		writes_n    = writes_q;
		status_n    = ST_OK;
		rdata_n     = 8'd0;
		alen_n      = '0;
		wr_en       = 1'b0;
		case (cmd_q)
			CMD_BYTE_RD: begin
				if (acc_ok_q) begin
					rdata_n     = rd_q;
					bytes_out_n = bytes_out_q + 32'd1;
					reads_n     = reads_q + 32'd1;
					ptr_n       = ptr_q + PW'(1);
				end else begin
					status_n = ST_REJECT;
				end
			end
			CMD_BYTE_WR: begin
				if (acc_ok_q) begin
					wr_en      = 1'b1;
					bytes_in_n = bytes_in_q + 32'd1;
					writes_n   = writes_q + 32'd1;
					ptr_n      = ptr_q + PW'(1);
				end else begin
					status_n = ST_REJECT;
				end
			end
			CMD_BULK_RD, CMD_BULK_WR: begin
				offset_n = off_eff_q;
				limit_n  = lim_eff_q;
				rej_n    = rej_eff_q;
				alen_n   = lim_eff_q;
				if (rej_eff_q) begin
					status_n = ST_REJECT;
				end else begin
					if (acc_ok_q) begin
						offset_n = off_eff_q + PW'(1);
						if (cmd_q == CMD_BULK_RD) begin
							rdata_n = rd_q;
						end else begin
							wr_en = 1'b1;
						end
					end else begin
						status_n = ST_DROP;
					end
					if (last_q) begin
						ptr_n = bulk_np_sat;
						rej_n = 1'b1;
						if (cmd_q == CMD_BULK_RD) begin
							bytes_out_n = bytes_out_q + 32'(lim_eff_q);
							reads_n     = reads_q + 32'd1;
						end else begin
							bytes_in_n = bytes_in_q + 32'(lim_eff_q);
							writes_n   = writes_q + 32'd1;
						end
					end
				end
			end
			CMD_SET_POS: begin
				if (CW'(newpos_q) < MEM_X) begin
					ptr_n = PW'(newpos_q);
				end else begin
					status_n = ST_REJECT;
				end
			end
			CMD_WINDOW: begin
				if (win_ok) begin
					ptr_n = PW'(prod_off_q);
				end else begin
					status_n = ST_REJECT;
				end
			end
			CMD_CLEAR: begin
				ptr_n       = '0;
				bytes_out_n = 32'd0;
				bytes_in_n  = 32'd0;
				reads_n     = 32'd0;
				writes_n    = 32'd0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.sweep_last = (sweep_addr_q == LAST_ADDR);
		stat.is_clear   = (cmd_q == CMD_CLEAR);
	end

	// item capture, calc stage and commit result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd_e_t'(cmd);
			data_q   <= data;
			length_q <= length;
			first_q  <= first;
			last_q   <= last;
			newpos_q <= new_position;
			bnum_q   <= block_number;
			bsize_q  <= block_size;
			bcount_q <= block_count;
		end
		if (ctl.calc) begin
			acc_ok_q    <= acc_ok;
			addr_q      <= rd_addr;
			off_eff_q   <= off_eff;
			lim_eff_q   <= lim_eff;
			rej_eff_q   <= rej_eff;
			prod_off_q  <= 32'(bnum_q) * 32'(bsize_q);
			prod_span_q <= 32'(bcount_q) * 32'(bsize_q);
		end
		if (ctl.commit) begin
			status        <= status_n;
			read_data     <= rdata_n;
			actual_length <= 13'(alen_n);
			position_now  <= 13'(ptr_n);
			total_read    <= bytes_out_n;
			total_written <= bytes_in_n;
			read_count    <= reads_n;
			write_count   <= writes_n;
		end
	end

	// byte store
	always_ff @(posedge clk) begin
		if (ctl.sweep) begin
			mem[sweep_addr_q] <= fill_q;
		end else if (ctl.commit && wr_en) begin
			mem[addr_q] <= data_q;
		end
		if (ctl.calc) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			offset_q     <= '0;
			limit_q      <= '0;
			rej_q        <= 1'b0;
			bytes_out_q  <= 32'd0;
			bytes_in_q   <= 32'd0;
			reads_q      <= 32'd0;
			writes_q     <= 32'd0;
			fill_q       <= 8'd0;
			sweep_addr_q <= '0;
		end else begin
			if (ctl.commit) begin
				ptr_q       <= ptr_n;
				offset_q    <= offset_n;
				limit_q     <= limit_n;
				rej_q       <= rej_n;
				bytes_out_q <= bytes_out_n;
				bytes_in_q  <= bytes_in_n;
				reads_q     <= reads_n;
				writes_q    <= writes_n;
				if (cmd_q == CMD_CLEAR) begin
					fill_q <= data_q;
				end
			end
			if (ctl.sweep) begin
				sweep_addr_q <= stat.sweep_last ? '0 : sweep_addr_q + AW'(1);
			end
		end
	end

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= MEM_P)
		else $error("pointer past end of store");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= limit_q)
		else $error("transfer offset past its limit");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && cmd_q == CMD_CLEAR) |=> (ptr_q == '0 && bytes_out_q == 32'd0
			&& bytes_in_q == 32'd0 && reads_q == 32'd0 && writes_q == 32'd0))
		else $error("clear left state behind");

endmodule

// ----- hw/rtl/ram_disk_byte_store_unit.sv -----
// top level of the byte store unit: controller and datapath
// the item is captured, the calc step follows, then the commit, which out_stall can hold
// input stalls until the commit (calc step with registered memory read, then commit)
// clear: the result is given first, then a fill sweep over the whole store holds off input
// reset: asynchronous; counters, pointer and transfer state go to zero, then a fill
// sweep writes zero to every address of the store while in_stall stays high
module ram_disk_byte_store_unit #(
	parameter int unsigned MEM_BYTES = rdbs_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data,
	input  logic [15:0] length,
	input  logic        first,
	input  logic        last,
	input  logic [15:0] new_position,
	input  logic [15:0] block_number,
	input  logic [15:0] block_size,
	input  logic [15:0] block_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  read_data,
	output logic [12:0] actual_length,
	output logic [12:0] position_now,
	output logic [31:0] total_read,
	output logic [31:0] total_written,
	output logic [31:0] read_count,
	output logic [31:0] write_count
);
	import rdbs_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	rdbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	rdbs_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.data          (data),
		.length        (length),
		.first         (first),
		.last          (last),
		.new_position  (new_position),
		.block_number  (block_number),
		.block_size    (block_size),
		.block_count   (block_count),
		.status        (status),
		.read_data     (read_data),
		.actual_length (actual_length),
		.position_now  (position_now),
		.total_read    (total_read),
		.total_written (total_written),
		.read_count    (read_count),
		.write_count   (write_count)
	);

endmodule
